// File: hdl/erds_pkg.sv
package erds_pkg;

    // rank selection mode, as held in the select_mode register
    typedef enum logic
    {
        MODE_LOWEST  = 1'b0,
        MODE_HIGHEST = 1'b1
    } erds_mode_t;

    // classification of one dimension, passed from front to back
    typedef struct packed
    {
        logic first;    // first dimension of a tuple
        logic last;     // final dimension of a tuple
        logic rated;    // rank defined and position within range
        logic exact;    // rank exactly at the extreme of the current mode
    } erds_flags_t;

    localparam int FLAGS_BITS = $bits(erds_flags_t);

    // configuration port
    localparam int  CFG_ADDR_BITS = 3;
    localparam int  CFG_DATA_BITS = 32;
    localparam logic CFG_IDX_SELECT_MODE = 1'b0;

    // output position field
    localparam int OUT_POS_BITS = 4;

endpackage

// File: hdl/erds_in_if.sv
interface erds_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] entry_value;
    logic [31:0]           entry_key;
    logic                  set_empty;
    logic [VALUE_BITS-1:0] min_value;
    logic [31:0]           min_key;
    logic [VALUE_BITS-1:0] max_value;
    logic [31:0]           max_key;
    logic                  last_dim;

    modport source
    (
        output valid, entry_value, entry_key, set_empty,
               min_value, min_key, max_value, max_key, last_dim,
        input  ready
    );

    modport sink
    (
        input  valid, entry_value, entry_key, set_empty,
               min_value, min_key, max_value, max_key, last_dim,
        output ready
    );
endinterface

// File: hdl/erds_out_if.sv
interface erds_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] chosen_dimension;
    logic       exact_extreme;

    modport source
    (
        output valid, chosen_dimension, exact_extreme,
        input  ready
    );

    modport sink
    (
        input  valid, chosen_dimension, exact_extreme,
        output ready
    );
endinterface

// File: hdl/erds_front.sv
module erds_front #(
    parameter int MAX_DIMS   = 16,
    parameter int VALUE_BITS = 32,
    parameter int CNT_BITS   = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    erds_in_if.sink                 entries,
    input  erds_pkg::erds_mode_t    mode,
    input  logic                    q_full,
    output logic                    push,
    output erds_pkg::erds_flags_t   flags,
    output logic [CNT_BITS-1:0]     pos,
    output logic [VALUE_BITS-1:0]   num,
    output logic [VALUE_BITS-1:0]   den
);

    localparam logic [VALUE_BITS-1:0] ONE   = {{(VALUE_BITS-1){1'b0}}, 1'b1};
    localparam logic [CNT_BITS-1:0]   LIMIT = CNT_BITS'(MAX_DIMS);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                skip_reg, skip_next;

    logic [VALUE_BITS:0] diff_v;
    logic [VALUE_BITS:0] diff_h;
    logic                below_min;
    logic                above_max;
    logic                defined;
    logic                in_range;
    logic                exact_c;
    logic                accept;

    assign diff_v = {entries.entry_value[VALUE_BITS-1], entries.entry_value}
                  - {entries.min_value[VALUE_BITS-1], entries.min_value};
    assign diff_h = {entries.max_value[VALUE_BITS-1], entries.max_value}
                  - {entries.min_value[VALUE_BITS-1], entries.min_value};

    // ordered by value, then key
    assign below_min = ($signed(entries.entry_value) < $signed(entries.min_value))
                    || (entries.entry_value == entries.min_value
                        && entries.entry_key < entries.min_key);
    assign above_max = ($signed(entries.max_value) < $signed(entries.entry_value))
                    || (entries.max_value == entries.entry_value
                        && entries.max_key < entries.entry_key);

    always_comb
    begin
        defined = 1'b1;
        num     = '0;
        den     = ONE;
        if (entries.set_empty)
        begin
            num = '0;
        end
        else if (entries.min_key == entries.max_key)
        begin
            num = ONE;
        end
        else if (below_min)
        begin
            num = '0;
        end
        else if (above_max)
        begin
            num = ONE;
        end
        else if (entries.max_value == entries.min_value)
        begin
            // zero span: rank undefined
            defined = 1'b0;
        end
        else
        begin
            num = diff_v[VALUE_BITS-1:0];
            den = diff_h[VALUE_BITS-1:0];
        end
    end

    assign in_range = (cnt_reg < LIMIT);
    assign exact_c  = (mode == erds_pkg::MODE_HIGHEST) ? (num == den) : (num == '0);

    assign entries.ready = skip_reg || !q_full;
    assign accept        = entries.valid && entries.ready;
    assign push          = accept && !skip_reg;

    assign pos         = cnt_reg;
    assign flags.first = (cnt_reg == '0);
    assign flags.last  = entries.last_dim;
    assign flags.rated = defined && in_range;
    assign flags.exact = defined && in_range && exact_c;

    always_comb
    begin
        cnt_next  = cnt_reg;
        skip_next = skip_reg;
        if (accept)
        begin
            if (skip_reg)
            begin
                if (entries.last_dim)
                begin
                    skip_next = 1'b0;
                    cnt_next  = '0;
                end
            end
            else if (entries.last_dim)
            begin
                cnt_next = '0;
            end
            else if (flags.exact)
            begin
                skip_next = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
            else if (in_range)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            skip_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            skip_reg <= skip_next;
        end
    end

endmodule

// File: hdl/erds_queue.sv
module erds_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             valid
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wptr_reg, wptr_next;
    logic [PTR_BITS-1:0] rptr_reg, rptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign valid = (count_reg != '0);
    assign dout  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

// File: hdl/erds_back.sv
module erds_back #(
    parameter int VALUE_BITS = 32,
    parameter int CNT_BITS   = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  erds_pkg::erds_mode_t    mode,
    input  logic                    q_valid,
    input  erds_pkg::erds_flags_t   flags,
    input  logic [CNT_BITS-1:0]     pos,
    input  logic [VALUE_BITS-1:0]   num,
    input  logic [VALUE_BITS-1:0]   den,
    output logic                    pop,
    erds_out_if.source              results
);

    localparam logic [VALUE_BITS-1:0] ONE = {{(VALUE_BITS-1){1'b0}}, 1'b1};

    logic [VALUE_BITS-1:0]   best_num_reg, best_num_next;
    logic [VALUE_BITS-1:0]   best_den_reg, best_den_next;
    logic [CNT_BITS-1:0]     best_pos_reg, best_pos_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CNT_BITS-1:0]     out_pos_reg, out_pos_next;
    logic                    out_exact_reg, out_exact_next;

    logic [VALUE_BITS-1:0]   eff_num;
    logic [VALUE_BITS-1:0]   eff_den;
    logic [CNT_BITS-1:0]     eff_pos;
    logic [2*VALUE_BITS-1:0] lhs;
    logic [2*VALUE_BITS-1:0] rhs;
    logic                    better;
    logic                    improve;
    logic                    emit;
    logic [CNT_BITS+3:0]     pos_ext;

    // running best is reloaded at the first dimension of each tuple
    always_comb
    begin
        if (flags.first)
        begin
            eff_num = (mode == erds_pkg::MODE_HIGHEST) ? '0 : ONE;
            eff_den = ONE;
            eff_pos = '0;
        end
        else
        begin
            eff_num = best_num_reg;
            eff_den = best_den_reg;
            eff_pos = best_pos_reg;
        end
    end

    assign lhs     = num * eff_den;
    assign rhs     = eff_num * den;
    assign better  = (mode == erds_pkg::MODE_HIGHEST) ? (lhs > rhs) : (lhs < rhs);
    assign improve = flags.rated && !flags.exact && better;

    assign pop  = q_valid && (!out_valid_reg || results.ready);
    assign emit = flags.exact || flags.last;

    always_comb
    begin
        best_num_next  = best_num_reg;
        best_den_next  = best_den_reg;
        best_pos_next  = best_pos_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_exact_next = out_exact_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            best_num_next = improve ? num : eff_num;
            best_den_next = improve ? den : eff_den;
            best_pos_next = improve ? pos : eff_pos;
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_exact_next = flags.exact;
                out_pos_next   = (flags.exact || improve) ? pos : eff_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_num_reg  <= best_num_next;
        best_den_reg  <= best_den_next;
        best_pos_reg  <= best_pos_next;
        out_pos_reg   <= out_pos_next;
        out_exact_reg <= out_exact_next;
    end

    // position is reported in its low four bits
    assign pos_ext = {4'b0000, out_pos_reg};

    assign results.valid            = out_valid_reg;
    assign results.chosen_dimension = pos_ext[erds_pkg::OUT_POS_BITS-1:0];
    assign results.exact_extreme    = out_exact_reg;

endmodule

// File: hdl/extreme_rank_dimension_select.sv
// extreme rank dimension select: picks the lowest or highest ranked dimension of a tuple
// throughput: one dimension transaction per cycle while the receiver takes results and the
//   queue has room, set by the combinational running-best compare (two cross products and a compare)
// a deciding transaction is registered in the queue, then in the output register
// reset: rst_n asynchronous, active low; clears counters, queue and output valid,
//   select_mode returns to lowest mode
module extreme_rank_dimension_select #(
    parameter int MAX_DIMS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // apb-style configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [erds_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [erds_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [erds_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // dimension transactions in, selection transactions out
    erds_in_if.sink                             entries,
    erds_out_if.source                          results
);

    // counter holds positions up to MAX_DIMS, where it saturates
    localparam int CNT_BITS = $clog2(MAX_DIMS + 1);
    localparam int REC_BITS = erds_pkg::FLAGS_BITS + CNT_BITS + 2 * VALUE_BITS;
    localparam int Q_DEPTH  = 2;

    erds_pkg::erds_mode_t mode_reg;

    logic                    cfg_write;
    logic                    cfg_hit;

    // front side of the queue
    logic                    push;
    logic                    q_full;
    erds_pkg::erds_flags_t   f_flags;
    logic [CNT_BITS-1:0]     f_pos;
    logic [VALUE_BITS-1:0]   f_num;
    logic [VALUE_BITS-1:0]   f_den;
    logic [REC_BITS-1:0]     q_din;

    // back side of the queue
    logic                    pop;
    logic                    q_valid;
    logic [REC_BITS-1:0]     q_dout;
    erds_pkg::erds_flags_t   b_flags;
    logic [CNT_BITS-1:0]     b_pos;
    logic [VALUE_BITS-1:0]   b_num;
    logic [VALUE_BITS-1:0]   b_den;

    // register index is the word address; only select_mode exists
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == erds_pkg::CFG_IDX_SELECT_MODE);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? {{(erds_pkg::CFG_DATA_BITS-1){1'b0}}, mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= erds_pkg::MODE_LOWEST;
        end
        else if (cfg_write)
        begin
            mode_reg <= erds_pkg::erds_mode_t'(pwdata[0]);
        end
    end

    // front: rank each dimension, track position and skip after an early exit
    erds_front #(
        .MAX_DIMS   (MAX_DIMS),
        .VALUE_BITS (VALUE_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .entries (entries),
        .mode    (mode_reg),
        .q_full  (q_full),
        .push    (push),
        .flags   (f_flags),
        .pos     (f_pos),
        .num     (f_num),
        .den     (f_den)
    );

    assign q_din = {f_flags, f_pos, f_num, f_den};

    // short queue decouples ranking from the running-best compare
    erds_queue #(
        .WIDTH (REC_BITS),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .full  (q_full),
        .pop   (pop),
        .dout  (q_dout),
        .valid (q_valid)
    );

    assign b_flags = erds_pkg::erds_flags_t'(q_dout[REC_BITS-1 -: erds_pkg::FLAGS_BITS]);
    assign b_pos   = q_dout[2*VALUE_BITS +: CNT_BITS];
    assign b_num   = q_dout[VALUE_BITS +: VALUE_BITS];
    assign b_den   = q_dout[0 +: VALUE_BITS];

    // back: cross-multiplied compare against the running best, output register
    erds_back #(
        .VALUE_BITS (VALUE_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .mode    (mode_reg),
        .q_valid (q_valid),
        .flags   (b_flags),
        .pos     (b_pos),
        .num     (b_num),
        .den     (b_den),
        .pop     (pop),
        .results (results)
    );

endmodule

// File: tb/tb.sv
module tb;

    // block configuration under test
    localparam int DIM_LIMIT     = 16;
    localparam int VAL_W         = 32;

    // run shape
    localparam int PHASE_ITEMS   = 390;      // random dimension transactions per phase
    localparam int HOLD_CYCLES   = 300;      // long receiver hold-off under pressure
    localparam int SETTLE_CYCLES = 8;        // idle margin once the owed selections are in
    localparam int CYCLE_LIMIT   = 200000;   // ~2000 transactions, worst gaps and stalls x10
    localparam int OWED_DEPTH    = 4096;     // ring of owed selections, far above what is in flight

    localparam erds_pkg::erds_mode_t MODE_LOW  = erds_pkg::MODE_LOWEST;
    localparam erds_pkg::erds_mode_t MODE_HIGH = erds_pkg::MODE_HIGHEST;

    localparam logic [erds_pkg::CFG_ADDR_BITS-1:0] MODE_ADDR =
        erds_pkg::CFG_ADDR_BITS'(4 * erds_pkg::CFG_IDX_SELECT_MODE);

    // one dimension of a tuple as it travels on the input channel
    typedef struct packed
    {
        logic [31:0] value;
        logic [31:0] key;
        logic        empty;
        logic [31:0] min_v;
        logic [31:0] min_k;
        logic [31:0] max_v;
        logic [31:0] max_k;
        logic        last;
    } dim_t;

    // one selection as it travels on the output channel
    typedef struct packed
    {
        logic [3:0] dim;
        logic       exact;
    } choice_t;

    // directed stimulus row: the dimension is sent copies times in a row,
    // the typed choice replaces the predicted one where given is set
    typedef struct packed
    {
        erds_pkg::erds_mode_t mode;
        dim_t                 d;
        logic [7:0]           copies;
        logic                 given;
        choice_t              want;
    } row_t;

    typedef struct packed
    {
        erds_pkg::erds_mode_t mode;
        logic [6:0]           idle;
        logic [6:0]           stall;
        logic                 hold;
    } phase_t;

    localparam int DIR_ROWS = 20;

    row_t dir_rows [DIR_ROWS] = '{
        // lowest mode: empty set ranks 0 and exits at once
        '{MODE_LOW, '{32'd0, 32'd0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1},
          8'd1, 1'b1, '{4'd0, 1'b1}},
        // single member ranks 1, never beats the initial best of 1
        '{MODE_LOW, '{32'd5, 32'd9, 1'b0, 32'd3, 32'd4, 32'd7, 32'd4, 1'b1},
          8'd1, 1'b1, '{4'd0, 1'b0}},
        // interior 1/2, then below the minimum through a key tie exits at position 1
        '{MODE_LOW, '{32'd5, 32'd3, 1'b0, 32'd0, 32'd1, 32'd10, 32'd2, 1'b0},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        '{MODE_LOW, '{32'd0, 32'd0, 1'b0, 32'd0, 32'd1, 32'd10, 32'd2, 1'b0},
          8'd1, 1'b1, '{4'd1, 1'b1}},
        // rest of the tuple is skipped, its end gives nothing
        '{MODE_LOW, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        // full range span: interior rank exactly 1, then 1/(2^32-1)
        '{MODE_LOW, '{32'h7FFF_FFFF, 32'd0, 1'b0, 32'h8000_0000, 32'd0,
                      32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        '{MODE_LOW, '{32'h8000_0001, 32'hFFFF_FFFF, 1'b0, 32'h8000_0000, 32'd0,
                      32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        // zero span closes the tuple and is never chosen
        '{MODE_LOW, '{32'd7, 32'd5, 1'b0, 32'd7, 32'd1, 32'd7, 32'd9, 1'b1},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        // too many dimensions: equal ranks past the limit, then an ignored empty set
        '{MODE_LOW, '{32'd5, 32'd3, 1'b0, 32'd0, 32'd1, 32'd10, 32'd2, 1'b0},
          8'd17, 1'b0, '{4'd0, 1'b0}},
        '{MODE_LOW, '{32'd0, 32'd0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1},
          8'd1, 1'b1, '{4'd0, 1'b0}},
        // entry equal to the minimum with a larger key: interior rank 0
        '{MODE_LOW, '{32'd0, 32'd5, 1'b0, 32'd0, 32'd1, 32'd10, 32'd2, 1'b1},
          8'd1, 1'b1, '{4'd0, 1'b1}},
        // highest mode: above the maximum by value
        '{MODE_HIGH, '{32'd100, 32'd0, 1'b0, 32'd0, 32'd1, 32'd50, 32'd2, 1'b1},
          8'd1, 1'b1, '{4'd0, 1'b1}},
        // 1/4, 3/4, below the minimum, then above the maximum by key tie exits at 3
        '{MODE_HIGH, '{32'd1, 32'd7, 1'b0, 32'd0, 32'd1, 32'd4, 32'd2, 1'b0},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        '{MODE_HIGH, '{32'd3, 32'd7, 1'b0, 32'd0, 32'd1, 32'd4, 32'd2, 1'b0},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        '{MODE_HIGH, '{32'h8000_0000, 32'd7, 1'b0, 32'd0, 32'd1, 32'd4, 32'd2, 1'b0},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        '{MODE_HIGH, '{32'd4, 32'd3, 1'b0, 32'd0, 32'd1, 32'd4, 32'd2, 1'b0},
          8'd1, 1'b1, '{4'd3, 1'b1}},
        '{MODE_HIGH, '{32'd0, 32'd0, 1'b0, 32'd0, 32'd1, 32'd4, 32'd2, 1'b1},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        // empty set gains nothing over 0, zero span ends it: position 0
        '{MODE_HIGH, '{32'd0, 32'd0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0},
          8'd1, 1'b0, '{4'd0, 1'b0}},
        '{MODE_HIGH, '{32'd7, 32'd5, 1'b0, 32'd7, 32'd1, 32'd7, 32'd9, 1'b1},
          8'd1, 1'b1, '{4'd0, 1'b0}},
        // single member ranks 1 and exits
        '{MODE_HIGH, '{32'd5, 32'd9, 1'b0, 32'd3, 32'd4, 32'd7, 32'd4, 1'b1},
          8'd1, 1'b1, '{4'd0, 1'b1}}
    };

    // random phases: idling mix and the mode each one runs in
    phase_t phases [5] = '{
        '{MODE_LOW,  7'd0,  7'd0,  1'b0},
        '{MODE_HIGH, 7'd49, 7'd0,  1'b0},
        '{MODE_LOW,  7'd0,  7'd49, 1'b0},
        '{MODE_HIGH, 7'd18, 7'd18, 1'b0},
        '{MODE_LOW,  7'd0,  7'd0,  1'b1}
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [erds_pkg::CFG_ADDR_BITS-1:0] paddr;
    logic [erds_pkg::CFG_DATA_BITS-1:0] pwdata;
    logic [erds_pkg::CFG_DATA_BITS-1:0] prdata;
    logic        pready;

    erds_in_if #(.VALUE_BITS(VAL_W)) dims_if ();
    erds_out_if                      picks_if ();

    extreme_rank_dimension_select #(
        .MAX_DIMS   (DIM_LIMIT),
        .VALUE_BITS (VAL_W)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .entries (dims_if),
        .results (picks_if)
    );

    // selector shadow: mode, running best and tuple position
    erds_pkg::erds_mode_t cur_mode = erds_pkg::MODE_LOWEST;
    logic [63:0] best_num   = 64'd0;
    logic [63:0] best_den   = 64'd1;
    int          best_pos   = 0;
    int          dim_pos    = 0;
    logic        skipping   = 1'b0;

    choice_t     owed_choices [OWED_DEPTH];   // selections still owed by the block
    logic [11:0] owed_wr      = '0;
    logic [11:0] owed_rd      = '0;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int          holds_asked  = 0;
    int          items_sent   = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // exact rank as num/den; returns 0 where the span is zero
    function automatic logic dim_rank(input dim_t d, output logic [63:0] num,
                                      output logic [63:0] den);
        longint v;
        longint lo;
        longint hi;
        v   = longint'($signed(d.value));
        lo  = longint'($signed(d.min_v));
        hi  = longint'($signed(d.max_v));
        num = 64'd0;
        den = 64'd1;
        if (d.empty)
            return 1'b1;
        if (d.min_k == d.max_k)
        begin
            num = 64'd1;
            return 1'b1;
        end
        if (v < lo || (v == lo && d.key < d.min_k))
            return 1'b1;
        if (hi < v || (hi == v && d.max_k < d.key))
        begin
            num = 64'd1;
            return 1'b1;
        end
        if (hi == lo)
            return 1'b0;
        num = 64'(v - lo);
        den = 64'(hi - lo);
        return 1'b1;
    endfunction

    // advances the shadow by one accepted dimension; returns 1 when it yields a selection
    function automatic logic predict_choice(input dim_t d, output choice_t c);
        logic [63:0] num;
        logic [63:0] den;
        logic        top;
        logic        better;
        top = (cur_mode == erds_pkg::MODE_HIGHEST);
        c   = '0;
        // after an early exit nothing counts until the tuple ends
        if (skipping)
        begin
            if (d.last)
            begin
                skipping = 1'b0;
                dim_pos  = 0;
            end
            return 1'b0;
        end
        if (dim_pos == 0)
        begin
            best_num = top ? 64'd0 : 64'd1;
            best_den = 64'd1;
            best_pos = 0;
        end
        // positions past the limit are not rated at all
        if (dim_pos < DIM_LIMIT && dim_rank(d, num, den))
        begin
            if (top ? (num == den) : (num == 64'd0))
            begin
                c.dim   = dim_pos[3:0];
                c.exact = 1'b1;
                if (d.last)
                    dim_pos = 0;
                else
                begin
                    skipping = 1'b1;
                    dim_pos  = dim_pos + 1;
                end
                return 1'b1;
            end
            // cross products stay below 2^64, no division needed
            better = top ? (num * best_den > best_num * den)
                         : (num * best_den < best_num * den);
            if (better)
            begin
                best_num = num;
                best_den = den;
                best_pos = dim_pos;
            end
        end
        if (d.last)
        begin
            c.dim   = best_pos[3:0];
            c.exact = 1'b0;
            dim_pos = 0;
            return 1'b1;
        end
        if (dim_pos < DIM_LIMIT)
            dim_pos = dim_pos + 1;
        return 1'b0;
    endfunction

    // value mix: extremes, a small window that makes ties, full range
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0:
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            1:       return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-ordered sets with an entry aimed at one rank class, some noise
    function automatic dim_t rand_dim(input logic last);
        dim_t        d;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        longint      span;
        int          cls;
        a = rand_value();
        b = rand_value();
        if ($signed(a) > $signed(b))
        begin
            t = a;
            a = b;
            b = t;
        end
        d.value = rand_value();
        d.key   = $urandom;
        d.empty = 1'b0;
        d.min_v = a;
        d.min_k = $urandom;
        d.max_v = b;
        d.max_k = $urandom;
        d.last  = last;
        cls     = $urandom_range(0, 99);
        if (cls < 6)
            d.empty = 1'b1;
        else if (cls < 12)
            d.max_k = d.min_k;
        else if (cls < 20)
        begin
            // equal to the minimum with a smaller key
            d.value = a;
            if (d.min_k == 32'd0)
                d.min_k = 32'd1;
            d.key = $urandom_range(d.min_k - 32'd1, 0);
        end
        else if (cls < 28)
        begin
            // equal to the maximum with a larger key
            d.value = b;
            if (d.max_k == 32'hFFFF_FFFF)
                d.max_k = 32'hFFFF_FFFE;
            d.key = $urandom_range(32'hFFFF_FFFF, d.max_k + 32'd1);
        end
        else if (cls < 38)
        begin
            // unordered set bounds
            d.min_v = rand_value();
            d.max_v = rand_value();
        end
        else if (cls < 44)
        begin
            // zero span with the entry between the keys
            d.max_v = a;
            d.value = a;
            d.min_k = $urandom_range(0, 32'h7FFF_FFFF);
            d.max_k = d.min_k + 32'd1 + 32'($urandom_range(0, 1000));
            d.key   = $urandom_range(d.max_k, d.min_k);
        end
        else
        begin
            // interior entry anywhere in the span
            span    = longint'($signed(b)) - longint'($signed(a));
            d.value = 32'(longint'($signed(a)) + longint'({32'b0, $urandom}) % (span + 1));
        end
        return d;
    endfunction

    // one apb transfer: setup cycle, then access until pready
    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MODE_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_mode(input erds_pkg::erds_mode_t m);
        logic [31:0] rd;
        apb_xfer(1'b0, 32'd0, rd);
        if (rd !== {31'd0, m})
            note_mismatch($sformatf("select_mode read expected %0h got %0h", m, rd));
    endtask

    task automatic set_mode(input erds_pkg::erds_mode_t m);
        logic [31:0] rd;
        apb_xfer(1'b1, {31'd0, m}, rd);
        cur_mode = m;
        check_mode(m);
    endtask

    // offer one dimension transaction, with random idle cycles ahead of it
    task automatic send_dim(input dim_t d, input logic given, input choice_t want);
        choice_t c;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            dims_if.valid <= 1'b0;
            @(posedge clk);
        end
        dims_if.valid       <= 1'b1;
        dims_if.entry_value <= d.value;
        dims_if.entry_key   <= d.key;
        dims_if.set_empty   <= d.empty;
        dims_if.min_value   <= d.min_v;
        dims_if.min_key     <= d.min_k;
        dims_if.max_value   <= d.max_v;
        dims_if.max_key     <= d.max_k;
        dims_if.last_dim    <= d.last;
        @(posedge clk);
        while (!dims_if.ready)
            @(posedge clk);
        if (predict_choice(d, c))
        begin
            owed_choices[owed_wr] = given ? want : c;
            owed_wr = owed_wr + 12'd1;
        end
    endtask

    // tuple lengths mostly short, a few past the dimension limit
    task automatic send_tuple();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            len = $urandom_range(1, 3);
        else if (pick < 85)
            len = $urandom_range(4, 8);
        else if (pick < 95)
            len = $urandom_range(9, 16);
        else
            len = $urandom_range(17, 20);
        for (int i = 0; i < len; i++)
        begin
            send_dim(rand_dim(i == len - 1), 1'b0, '0);
            items_sent++;
        end
    endtask

    // idle the input, collect every owed selection, then let skipped tails finish
    task automatic settle();
        dims_if.valid <= 1'b0;
        while (owed_wr != owed_rd)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // receiver: random stalls, plus a counted hold-off when one is requested
    initial
    begin : receiver
        int hold_left;
        int holds_served;
        hold_left      = 0;
        holds_served   = 0;
        picks_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                picks_if.ready <= 1'b0;
                hold_left--;
            end
            else if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                picks_if.ready <= 1'b0;
            end
            else
                picks_if.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // compare each selection transaction with the oldest owed one
    always @(posedge clk)
    begin
        choice_t want;
        if (rst_n && picks_if.valid && picks_if.ready)
        begin
            if (owed_wr == owed_rd)
                note_mismatch($sformatf("unexpected selection dimension %0d exact %0b",
                                        picks_if.chosen_dimension, picks_if.exact_extreme));
            else
            begin
                want    = owed_choices[owed_rd];
                owed_rd = owed_rd + 12'd1;
                if (want.dim !== picks_if.chosen_dimension
                    || want.exact !== picks_if.exact_extreme)
                    note_mismatch($sformatf({"dimension expected %0d got %0d, ",
                                             "exact_extreme expected %0b got %0b"},
                                            want.dim, picks_if.chosen_dimension,
                                            want.exact, picks_if.exact_extreme));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        dims_if.valid       = 1'b0;
        dims_if.entry_value = '0;
        dims_if.entry_key   = '0;
        dims_if.set_empty   = 1'b0;
        dims_if.min_value   = '0;
        dims_if.min_key     = '0;
        dims_if.max_value   = '0;
        dims_if.max_key     = '0;
        dims_if.last_dim    = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // register comes out of reset in lowest mode
        check_mode(erds_pkg::MODE_LOWEST);

        // directed table, no idling on either side
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].mode != cur_mode)
            begin
                settle();
                set_mode(dir_rows[r].mode);
            end
            for (int c = 0; c < dir_rows[r].copies; c++)
                send_dim(dir_rows[r].d, dir_rows[r].given, dir_rows[r].want);
        end

        // random phases, the mode rewritten while idle at each boundary
        foreach (phases[p])
        begin
            settle();
            set_mode(phases[p].mode);
            stall_pct  = int'(phases[p].stall);
            items_sent = 0;
            // block fills up while the receiver holds off
            if (phases[p].hold)
                holds_asked++;
            while (items_sent < PHASE_ITEMS)
            begin
                // some tuples go through without sender gaps
                idle_pct = ($urandom_range(0, 7) == 0) ? 0 : int'(phases[p].idle);
                send_tuple();
            end
        end

        stall_pct = 0;
        settle();
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
